// ===== rtl/core/mini_mips_core_macros.svh =====
// Assertion macros used by the port-level checker of the small MIPS core.
`ifndef MINI_MIPS_CORE_MACROS_SVH
`define MINI_MIPS_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MMC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mmc_pkg.sv =====
// Shared constants, opcodes and structures of the small MIPS core.
package mmc_pkg;

  // Memory and datapath geometry.
  localparam int MEM_BYTES = 2048;
  localparam int DATA_BASE = 800;
  localparam int CODE_BASE = 65536;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int BANKS     = 4;
  localparam int BANK_W    = $clog2(BANKS);
  localparam int ROWS      = MEM_BYTES / BANKS;
  localparam int ROW_AW    = MEM_AW - BANK_W;
  localparam int PC_W      = 16;
  localparam int CNT_W     = 10;
  localparam int REG_AW    = 5;
  localparam int NREGS     = 32;
  localparam int XLEN      = 32;

  // Item kinds.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Primary opcodes.
  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_REGIMM  = 6'h01;
  localparam logic [5:0] OPC_J       = 6'h02;
  localparam logic [5:0] OPC_JAL     = 6'h03;
  localparam logic [5:0] OPC_BNE     = 6'h05;
  localparam logic [5:0] OPC_ADDI    = 6'h08;
  localparam logic [5:0] OPC_LW      = 6'h23;

  // Function codes under the special opcode.
  localparam logic [5:0] FN_SLL = 6'h00;
  localparam logic [5:0] FN_ADD = 6'h20;

  // Unified memory port: one read and one write address.
  typedef struct packed {
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
  } umem_req_t;

  // Register file port: two reads and one write.
  typedef struct packed {
    logic              rd_en;
    logic [REG_AW-1:0] rs_addr;
    logic [REG_AW-1:0] rt_addr;
    logic              wr_en;
    logic [REG_AW-1:0] wr_addr;
    logic [XLEN-1:0]   wr_data;
  } rf_req_t;

  // One finished result.
  typedef struct packed {
    logic [PC_W-1:0]   pc_value;
    logic              dest_valid;
    logic [REG_AW-1:0] dest_reg;
    logic [XLEN-1:0]   dest_value;
    logic              halted;
  } result_t;

endpackage

// ===== rtl/core/mmc_stream_if.sv =====
// Request and result channel interfaces of the small MIPS core.
interface mmc_cmd_if import mmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [MEM_AW-1:0] mem_address;
  logic [7:0]        mem_byte;

  modport source (output valid, op, mem_address, mem_byte, input ready);
  modport sink   (input valid, op, mem_address, mem_byte, output ready);
endinterface

interface mmc_res_if import mmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PC_W-1:0]   pc_value;
  logic              dest_valid;
  logic [REG_AW-1:0] dest_reg;
  logic [XLEN-1:0]   dest_value;
  logic              halted;

  modport source (output valid, pc_value, dest_valid, dest_reg, dest_value, halted,
                  input ready);
  modport sink   (input valid, pc_value, dest_valid, dest_reg, dest_value, halted,
                  output ready);
endinterface

// ===== rtl/core/mmc_umem.sv =====
// Unified byte memory, banked four ways so that one unaligned word reads per cycle.
module mmc_umem import mmc_pkg::*; (
  input  logic            clk,
  input  umem_req_t       req,
  output logic [XLEN-1:0] rd_word
);

  logic [7:0]        rd_byte [BANKS];
  logic [BANK_W-1:0] rot;

  // Each bank holds every fourth byte; a bank below the start offset reads the next row.
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [7:0]        bank_mem [ROWS];
    logic [ROW_AW-1:0] rd_row;

    assign rd_row = req.rd_addr[MEM_AW-1:BANK_W]
                  + ROW_AW'((BANK_W'(b) < req.rd_addr[BANK_W-1:0]) ? 1 : 0);

    always_ff @(posedge clk) begin
      if (req.wr_en && (req.wr_addr[BANK_W-1:0] == BANK_W'(b))) begin
        bank_mem[req.wr_addr[MEM_AW-1:BANK_W]] <= req.wr_data;
      end
      if (req.rd_en) begin
        rd_byte[b] <= bank_mem[rd_row];
      end
    end
  end

  // The start offset is kept to rotate the bytes into big-endian order.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rot <= req.rd_addr[BANK_W-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < BANKS; k++) begin
      rd_word[XLEN-1-8*k -: 8] = rd_byte[BANK_W'(rot + BANK_W'(k))];
    end
  end

endmodule

// ===== rtl/core/mmc_regfile.sv =====
// General register file with two registered read ports and per-entry valid bits.
module mmc_regfile import mmc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  rf_req_t         req,
  output logic [XLEN-1:0] rs_data,
  output logic [XLEN-1:0] rt_data
);

  logic [XLEN-1:0]  rf_mem [NREGS];
  logic [NREGS-1:0] rf_valid;
  logic [XLEN-1:0]  rs_q;
  logic [XLEN-1:0]  rt_q;
  logic             rs_vld;
  logic             rt_vld;

  // An entry reads as zero until it has been written since reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
    end else if (req.wr_en) begin
      rf_valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      rf_mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read data is held until the next read is issued.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rs_q   <= rf_mem[req.rs_addr];
      rt_q   <= rf_mem[req.rt_addr];
      rs_vld <= rf_valid[req.rs_addr];
      rt_vld <= rf_valid[req.rt_addr];
    end
  end

  assign rs_data = rs_vld ? rs_q : '0;
  assign rt_data = rt_vld ? rt_q : '0;

endmodule

// ===== rtl/core/mmc_exec.sv =====
// Sequencer and execute datapath: fetch, register read, execute and load.
module mmc_exec import mmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  mmc_cmd_if.sink          cmd,
  output umem_req_t        umem_req,
  input  logic [XLEN-1:0]  umem_word,
  output rf_req_t          rf_req,
  input  logic [XLEN-1:0]  rs_data,
  input  logic [XLEN-1:0]  rt_data,
  output logic             push,
  output result_t          push_res,
  input  logic             push_ok
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_FETCH = 5'b00100,
    S_EXEC  = 5'b01000,
    S_LOAD  = 5'b10000
  } state_t;

  localparam logic [PC_W-1:0]   CODE_BASE_LO = PC_W'(CODE_BASE);
  localparam logic [MEM_AW-1:0] DATA_BASE_LO = MEM_AW'(DATA_BASE);

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  instruction_count;
  logic [PC_W-1:0]   pc;
  logic              it_op;
  logic [MEM_AW-1:0] it_addr;
  logic [7:0]        it_byte;
  logic [XLEN-1:0]   instr;

  logic              accept;
  logic              done;
  logic              instr_load;
  logic              halt_now;
  logic [PC_W-1:0]   pc_plus4;
  logic [5:0]        opc;
  logic [5:0]        fn;
  logic [REG_AW-1:0] rt;
  logic [REG_AW-1:0] rd;
  logic [4:0]        sh;
  logic [XLEN-1:0]   imm;
  logic [PC_W-1:0]   br_off;
  logic [PC_W-1:0]   jmp_pc;
  logic [MEM_AW-1:0] ld_addr;

  logic              ex_wr;
  logic [REG_AW-1:0] ex_reg;
  logic [XLEN-1:0]   ex_val;
  logic [PC_W-1:0]   ex_pc;
  logic              ex_load;

  logic              fin_wr;
  logic              fin_dest;
  logic [REG_AW-1:0] fin_reg;
  logic [XLEN-1:0]   fin_val;
  logic [PC_W-1:0]   fin_pc;

  // Instruction fields.
  assign opc      = instr[31:26];
  assign rt       = instr[20:16];
  assign rd       = instr[15:11];
  assign sh       = instr[10:6];
  assign fn       = instr[5:0];
  assign imm      = {{(XLEN-16){instr[15]}}, instr[15:0]};
  assign br_off   = {imm[PC_W-3:0], 2'b00};
  assign jmp_pc   = {instr[PC_W-3:0], 2'b00} - CODE_BASE_LO;
  assign ld_addr  = rs_data[MEM_AW-1:0] + imm[MEM_AW-1:0] + DATA_BASE_LO;
  assign pc_plus4 = pc + PC_W'(4);
  assign halt_now = pc[PC_W-1:2] >= (PC_W-2)'(instruction_count);

  // Execute: register result and next program counter of one instruction.
  always_comb begin
    ex_wr   = 1'b0;
    ex_reg  = rd;
    ex_val  = rs_data + rt_data;
    ex_pc   = pc_plus4;
    ex_load = 1'b0;
    case (opc)
      OPC_SPECIAL: begin
        case (fn)
          FN_ADD: begin
            ex_wr  = 1'b1;
            ex_val = rs_data + rt_data;
          end
          FN_SLL: begin
            ex_wr  = 1'b1;
            ex_val = rt_data << sh;
          end
          default: ;
        endcase
      end
      OPC_REGIMM, OPC_JAL: begin
        ex_pc = pc;
      end
      OPC_J: begin
        ex_pc = jmp_pc;
      end
      OPC_BNE: begin
        if (rs_data != rt_data) begin
          ex_pc = pc_plus4 + br_off;
        end
      end
      OPC_ADDI: begin
        ex_wr  = 1'b1;
        ex_reg = rt;
        ex_val = rs_data + imm;
      end
      OPC_LW: begin
        ex_load = 1'b1;
      end
      default: ;
    endcase
  end

  // A new request is taken when idle or in the cycle that hands a result over.
  assign cmd.ready = (state == S_IDLE) || (done && push_ok);
  assign accept    = cmd.valid && cmd.ready;
  assign push      = done && push_ok;

  // Sequencer and memory requests.
  always_comb begin
    state_next = state;
    done       = 1'b0;
    instr_load = 1'b0;
    fin_pc     = pc;
    fin_wr     = 1'b0;
    fin_reg    = rt;
    fin_val    = umem_word;
    umem_req   = '0;
    rf_req     = '0;
    case (state)
      S_IDLE: ;
      S_ISSUE: begin
        if ((it_op == OP_WRITE) || halt_now) begin
          done             = 1'b1;
          umem_req.wr_en   = (it_op == OP_WRITE) && push_ok;
          umem_req.wr_addr = it_addr;
          umem_req.wr_data = it_byte;
        end else begin
          umem_req.rd_en   = 1'b1;
          umem_req.rd_addr = pc[MEM_AW-1:0];
          state_next       = S_FETCH;
        end
      end
      S_FETCH: begin
        rf_req.rd_en   = 1'b1;
        rf_req.rs_addr = umem_word[25:21];
        rf_req.rt_addr = umem_word[20:16];
        instr_load     = 1'b1;
        state_next     = S_EXEC;
      end
      S_EXEC: begin
        if (ex_load) begin
          umem_req.rd_en   = 1'b1;
          umem_req.rd_addr = ld_addr;
          state_next       = S_LOAD;
        end else begin
          done    = 1'b1;
          fin_pc  = ex_pc;
          fin_wr  = ex_wr;
          fin_reg = ex_reg;
          fin_val = ex_val;
        end
      end
      S_LOAD: begin
        done    = 1'b1;
        fin_pc  = pc_plus4;
        fin_wr  = 1'b1;
        fin_reg = rt;
        fin_val = umem_word;
      end
      default: state_next = S_IDLE;
    endcase

    if (push) begin
      state_next = accept ? S_ISSUE : S_IDLE;
    end else if ((state == S_IDLE) && accept) begin
      state_next = S_ISSUE;
    end

    fin_dest       = fin_wr && (fin_reg != '0);
    rf_req.wr_en   = push && fin_dest;
    rf_req.wr_addr = fin_reg;
    rf_req.wr_data = fin_val;
  end

  // Result of the item that completes this cycle.
  always_comb begin
    push_res.pc_value   = fin_pc;
    push_res.dest_valid = fin_dest;
    push_res.dest_reg   = fin_dest ? fin_reg : '0;
    push_res.dest_value = fin_dest ? fin_val : '0;
    push_res.halted     = fin_pc[PC_W-1:2] >= (PC_W-2)'(instruction_count);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      pc                <= '0;
      instruction_count <= '0;
    end else begin
      state <= state_next;
      if (push) begin
        pc <= fin_pc;
      end
      if (cfg_wr_en) begin
        instruction_count <= cfg_wr_data;
      end
    end
  end

  // Captured request and instruction word.
  always_ff @(posedge clk) begin
    if (accept) begin
      it_op   <= cmd.op;
      it_addr <= cmd.mem_address;
      it_byte <= cmd.mem_byte;
    end
    if (instr_load) begin
      instr <= umem_word;
    end
  end

endmodule

// ===== rtl/core/mini_mips_core.sv =====
// Top level of the small MIPS core: memories, sequencer and result register.
//
// Requests arrive on cmd and are taken when valid and ready are both high.
// A request with op 0 stores mem_byte at mem_address in the unified memory;
// a request with op 1 executes the instruction at the program counter.
// Every request gives exactly one result on res, in request order.
// A byte write or a step while halted finishes in the issue state; an
// instruction passes through issue, fetch and execute, and lw also load.
// The next request is taken in the cycle a result is handed over, so writes
// run at one per cycle while res is not stalled; an instruction or lw waits
// for the fetch, register read and load through the registered reads of
// the banked memory and the register file. instruction_count is to be written
// through cfg_wr_en and cfg_wr_data only while idle; the block does not enforce it.
// Reset clears the program counter, the count and the register valid bits at
// once, so there is no clearing pass; the byte memory is undefined until
// written. While res is stalled the result waits in its register, one more
// request is still taken and runs up to its last step, where it waits until
// room frees.
module mini_mips_core import mmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  mmc_cmd_if.sink          cmd,
  mmc_res_if.source        res
);

  umem_req_t       umem_req;
  logic [XLEN-1:0] umem_word;
  rf_req_t         rf_req;
  logic [XLEN-1:0] rs_data;
  logic [XLEN-1:0] rt_data;
  logic            push;
  logic            push_ok;
  result_t         push_res;
  logic            out_valid;
  result_t         out_res;

  mmc_umem u_umem (
    .clk     (clk),
    .req     (umem_req),
    .rd_word (umem_word)
  );

  mmc_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .req     (rf_req),
    .rs_data (rs_data),
    .rt_data (rt_data)
  );

  mmc_exec u_exec (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .umem_req    (umem_req),
    .umem_word   (umem_word),
    .rf_req      (rf_req),
    .rs_data     (rs_data),
    .rt_data     (rt_data),
    .push        (push),
    .push_res    (push_res),
    .push_ok     (push_ok)
  );

  // Output register: a new result may enter when it is empty or being taken.
  assign push_ok = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= push || (out_valid && !res.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res <= push_res;
    end
  end

  assign res.valid      = out_valid;
  assign res.pc_value   = out_res.pc_value;
  assign res.dest_valid = out_res.dest_valid;
  assign res.dest_reg   = out_res.dest_reg;
  assign res.dest_value = out_res.dest_value;
  assign res.halted     = out_res.halted;

endmodule

// ===== rtl/core/mmc_checker.sv =====
// Port-level checker of the small MIPS core, bound to its top level.
`include "mini_mips_core_macros.svh"

module mmc_checker import mmc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              cfg_wr_en,
  input logic [CNT_W-1:0]  cfg_wr_data,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic [PC_W-1:0]   res_pc_value,
  input logic              res_dest_valid,
  input logic [REG_AW-1:0] res_dest_reg,
  input logic [XLEN-1:0]   res_dest_value,
  input logic              res_halted
);

  logic [1:0]       pending;
  logic [CNT_W-1:0] count_copy;
  logic             cmd_acc;
  logic             res_acc;

  assign cmd_acc = cmd_valid && cmd_ready;
  assign res_acc = res_valid && res_ready;

  // Requests taken but not yet answered, and a copy of the configured count.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      count_copy <= '0;
    end else begin
      pending <= pending + 2'(cmd_acc) - 2'(res_acc);
      if (cfg_wr_en) begin
        count_copy <= cfg_wr_data;
      end
    end
  end

  // A result only ever answers a request that was taken.
  `MMC_ASSERT_SAME(a_no_spurious, res_valid, pending != 2'd0, "result without a request")

  // No register write means the destination fields read as zero.
  `MMC_ASSERT_SAME(a_dest_clear, res_valid && !res_dest_valid, (res_dest_reg == '0) && (res_dest_value == '0), "stale destination fields")

  // Register zero is never reported as written.
  `MMC_ASSERT_SAME(a_dest_nonzero, res_valid && res_dest_valid, res_dest_reg != '0, "write to register zero reported")

  // The halt flag follows the program counter and the configured count.
  `MMC_ASSERT_SAME(a_halt_flag, res_valid, res_halted == (res_pc_value[PC_W-1:2] >= (PC_W-2)'(count_copy)), "halt flag disagrees with pc")

  // A stalled result stays valid and keeps its pc and destination value.
  `MMC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_pc_value) && $stable(res_dest_value), "stalled result changed")

endmodule

bind mini_mips_core mmc_checker u_mmc_checker (
  .clk            (clk),
  .rst            (rst),
  .cfg_wr_en      (cfg_wr_en),
  .cfg_wr_data    (cfg_wr_data),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_pc_value   (res.pc_value),
  .res_dest_valid (res.dest_valid),
  .res_dest_reg   (res.dest_reg),
  .res_dest_value (res.dest_value),
  .res_halted     (res.halted)
);
